>>> src/csa_pkg.sv
// ----------------------------------------------------------------------------
// Cosine similarity accumulator package
// Shared word types, widths and the control-state encoding.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int ELEM_W   = 16;
  localparam int SUM_W    = 48;
  localparam int FLOOR_W  = 20;
  localparam int ROOT_W   = 64;
  localparam int QUOT_W   = 32;
  localparam int STEP_W   = 5;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(11);

  // One accepted element pair.
  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_a;
    logic signed [ELEM_W-1:0] elem_b;
    logic                     last_element;
  } item_t;

  // One similarity result.
  typedef struct packed {
    logic signed [ELEM_W-1:0] cosine;
    logic                     degenerate;
  } result_t;

  // Finished sums of one vector pair, handed from front to back.
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_ab;
    logic signed [SUM_W-1:0] sum_aa;
    logic signed [SUM_W-1:0] sum_bb;
  } sums_t;

  // Handshake between the queue and a side that uses it.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_WRITE
  } back_state_t;

endpackage

>>> src/csa_front.sv
// ----------------------------------------------------------------------------
// Cosine similarity front end
// Accepts element pairs, keeps the three saturating sums and hands the
// finished sums to the queue on the last pair of each vector.
// ----------------------------------------------------------------------------
module csa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csa_pkg::item_t item,
  output logic           full,
  input  csa_pkg::qstat_t qstat,
  output logic           q_push,
  output csa_pkg::sums_t q_data
);
  import csa_pkg::*;

  logic                    accept;
  logic signed [SUM_W-1:0] sum_ab, sum_aa, sum_bb;
  logic signed [SUM_W-1:0] sum_ab_next, sum_aa_next, sum_bb_next;

  // Add a product to a sum, clamping at the 48-bit limits.
  function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] acc,
      input logic signed [2*ELEM_W-1:0] p);
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(acc) + (SUM_W+1)'(p);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  // No pair, last or not, can go in while the queue has no room.
  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  // Sums including the current pair.
  always_comb begin
    sum_ab_next = sat_add(sum_ab, item.elem_a * item.elem_b);
    sum_aa_next = sat_add(sum_aa, item.elem_a * item.elem_a);
    sum_bb_next = sat_add(sum_bb, item.elem_b * item.elem_b);
  end

  assign q_push = accept && item.last_element;
  assign q_data = '{sum_ab: sum_ab_next, sum_aa: sum_aa_next, sum_bb: sum_bb_next};

  // Accumulators, cleared after every vector.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ab <= '0;
      sum_aa <= '0;
      sum_bb <= '0;
    end else if (accept) begin
      if (item.last_element) begin
        sum_ab <= '0;
        sum_aa <= '0;
        sum_bb <= '0;
      end else begin
        sum_ab <= sum_ab_next;
        sum_aa <= sum_aa_next;
        sum_bb <= sum_bb_next;
      end
    end
  end

endmodule

>>> src/csa_queue.sv
// ----------------------------------------------------------------------------
// Cosine similarity sums queue
// Short queue of finished sums between the front end and the back end.
// ----------------------------------------------------------------------------
module csa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  csa_pkg::sums_t  wdata,
  input  logic            pop,
  output csa_pkg::sums_t  rdata,
  output csa_pkg::qstat_t stat
);
  import csa_pkg::*;

  sums_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign stat.full  = (count == QCNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = slots[rptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/csa_back.sv
// ----------------------------------------------------------------------------
// Cosine similarity back end
// Takes finished sums, forms both norms by shared-step square roots, the
// denominator, a bit-serial quotient, and holds the result word.
// ----------------------------------------------------------------------------
module csa_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [csa_pkg::FLOOR_W-1:0]   floor_val,
  input  csa_pkg::qstat_t               qstat,
  input  csa_pkg::sums_t                q_data,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output csa_pkg::result_t              result
);
  import csa_pkg::*;

  back_state_t state, state_next;

  logic signed [SUM_W-1:0] sum_ab;
  logic [ROOT_W-1:0]       xa, xb, ra, rb, bitv, den, rem;
  logic [QUOT_W-1:0]       quot;
  logic [STEP_W-1:0]       step;
  logic [SUM_W-1:0]        mag;
  logic                    deg;
  logic                    res_valid;
  logic                    do_write;
  logic                    last_step;

  logic [ROOT_W-1:0]       ta, tb;
  logic [ROOT_W:0]         rem2;
  logic [QUOT_W:0]         qr;
  logic [ELEM_W-1:0]       cos_val;

  assign empty     = !res_valid;
  assign last_step = (step == {STEP_W{1'b1}});
  assign mag       = sum_ab[SUM_W-1] ? SUM_W'(-sum_ab) : SUM_W'(sum_ab);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!qstat.empty) state_next = ST_ROOT;
      ST_ROOT:  if (last_step) state_next = ST_MUL;
      ST_MUL:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (den <= {28'b0, floor_val, 16'b0} || {16'b0, mag} >= den) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_DIV;
        end
      end
      ST_DIV:   if (last_step) state_next = ST_WRITE;
      ST_WRITE: if (!res_valid || pop) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the control.
  always_comb begin
    q_pop    = (state == ST_IDLE) && !qstat.empty;
    do_write = (state == ST_WRITE) && (!res_valid || pop);
  end

  // Trial subtractions of one root step and one divide step.
  always_comb begin
    ta   = ra + bitv;
    tb   = rb + bitv;
    rem2 = {rem, 1'b0};
  end

  // Round half away from zero and saturate.
  always_comb begin
    qr = ({1'b0, quot} + (QUOT_W+1)'(1)) >> 1;
    if (deg) begin
      cos_val = '0;
    end else if (sum_ab[SUM_W-1]) begin
      cos_val = (qr > (QUOT_W+1)'(32768)) ? 16'h8000 : ELEM_W'(-qr[ELEM_W-1:0]);
    end else begin
      cos_val = (qr > (QUOT_W+1)'(32767)) ? 16'h7fff : qr[ELEM_W-1:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        sum_ab <= q_data.sum_ab;
        xa     <= q_data.sum_aa[SUM_W-1] ? '0 : {1'b0, q_data.sum_aa[SUM_W-2:0], 16'b0};
        xb     <= q_data.sum_bb[SUM_W-1] ? '0 : {1'b0, q_data.sum_bb[SUM_W-2:0], 16'b0};
        ra     <= '0;
        rb     <= '0;
        bitv   <= {2'b01, {(ROOT_W-2){1'b0}}};
        step   <= '0;
      end
      ST_ROOT: begin
        if (xa >= ta) begin
          xa <= xa - ta;
          ra <= (ra >> 1) + bitv;
        end else begin
          ra <= ra >> 1;
        end
        if (xb >= tb) begin
          xb <= xb - tb;
          rb <= (rb >> 1) + bitv;
        end else begin
          rb <= rb >> 1;
        end
        bitv <= bitv >> 2;
        step <= step + 1'b1;
      end
      ST_MUL: begin
        den <= ra[QUOT_W-1:0] * rb[QUOT_W-1:0];
      end
      ST_CHECK: begin
        rem  <= {16'b0, mag};
        step <= '0;
        if (den <= {28'b0, floor_val, 16'b0}) begin
          deg  <= 1'b1;
          quot <= '0;
        end else if ({16'b0, mag} >= den) begin
          deg  <= 1'b0;
          quot <= '1;
        end else begin
          deg  <= 1'b0;
          quot <= '0;
        end
      end
      ST_DIV: begin
        if (rem2 >= {1'b0, den}) begin
          rem  <= ROOT_W'(rem2 - {1'b0, den});
          quot <= {quot[QUOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem2[ROOT_W-1:0];
          quot <= {quot[QUOT_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
      end
      ST_WRITE: begin
      end
      default: begin
      end
    endcase
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (do_write) begin
      result <= '{cosine: cos_val, degenerate: deg};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (do_write) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/cosine_similarity_accumulator_top.sv
// A vector's result word is formed after its last pair is accepted: the back end takes the sums,
// runs 32 shared root steps, a multiply, a check and up to 32 divide steps, then writes
// the word once the previous one is popped; degenerate and saturated vectors skip the divide.
// Throughput: one element pair per cycle while the sums queue has room; the back end
// takes one vector at a time, so short vectors stall input once the two-entry queue fills.
// Reset: synchronous; clears the sums, the queue, the result valid flag, floor set to 11.
// ----------------------------------------------------------------------------
// Cosine similarity accumulator top level
// Front end, sums queue, back end and the denominator floor register.
// ----------------------------------------------------------------------------
module cosine_similarity_accumulator_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  csa_pkg::item_t              item,
  output logic                        empty,
  input  logic                        pop,
  output csa_pkg::result_t            result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [csa_pkg::FLOOR_W-1:0] cfg_data
);
  import csa_pkg::*;

  logic [FLOOR_W-1:0] floor_val;
  qstat_t             qstat;
  logic               q_push, q_pop;
  sums_t              q_wdata, q_rdata;

  // Floor register; always writable.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      floor_val <= FLOOR_RESET;
    end else if (cfg_valid) begin
      floor_val <= cfg_data;
    end
  end

  csa_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .qstat  (qstat),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  csa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (qstat)
  );

  csa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .floor_val (floor_val),
    .qstat     (qstat),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule

>>> test/cosine_similarity_accumulator_top_tb.sv
// ----------------------------------------------------------------------------
// Cosine similarity accumulator testbench
// Streams element pairs through the block, predicts every similarity word
// from running sums kept here, and compares each popped word with the oldest
// prediction. A directed table covers extremes and degenerate vectors, then
// random vectors follow under several floor settings with random idling.
// ----------------------------------------------------------------------------
module cosine_similarity_accumulator_top_tb;
  import csa_pkg::*;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int     DRAIN_WAIT  = 100;
  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  item_t item = '0;
  logic empty;
  logic pop = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [FLOOR_W-1:0] cfg_data = '0;

  // Predictor state
  logic signed [47:0] dot_acc, norm_a_acc, norm_b_acc;
  logic [FLOOR_W-1:0] floor_reg;
  result_t expected_words[$];
  int errors = 0;
  longint cycles = 0;
  bit pop_enable = 1'b1;

  // Directed table; a checked row carries a word typed in by hand.
  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    bit last;
    bit fixed;
    result_t word;
  } row_t;
  row_t rows[$];

  cosine_similarity_accumulator_top uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturating add of one product into a 48-bit sum.
  function automatic logic signed [47:0] sat_sum(logic signed [47:0] acc,
                                                  logic signed [47:0] p);
    logic signed [48:0] r;
    r = {acc[47], acc} + {p[47], p};
    if (r > 49'sh0_7FFF_FFFF_FFFF) return ACC_MAX;
    if (r < -49'sh0_8000_0000_0000) return ACC_MIN;
    return r[47:0];
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Accumulates one pair; returns 1 with the similarity word on a last pair.
  function automatic bit predict_cosine(logic signed [15:0] a, logic signed [15:0] b,
                                        bit last, output result_t w);
    logic [63:0] aa, bb, den, mag, q, r;
    bit neg;
    dot_acc    = sat_sum(dot_acc, 48'(a * b));
    norm_a_acc = sat_sum(norm_a_acc, 48'(a * a));
    norm_b_acc = sat_sum(norm_b_acc, 48'(b * b));
    w = '0;
    if (!last) return 1'b0;
    aa = norm_a_acc < 0 ? 64'd0 : 64'(norm_a_acc);
    bb = norm_b_acc < 0 ? 64'd0 : 64'(norm_b_acc);
    den = int_root(aa << 16) * int_root(bb << 16);
    if (den <= (64'(floor_reg) << 16)) begin
      w.degenerate = 1'b1;
    end else begin
      neg = dot_acc < 0;
      mag = neg ? 64'(-dot_acc) : 64'(dot_acc);
      if (mag / den != 0) begin
        q = 64'hFFFF_FFFF;
      end else begin
        r = mag;
        q = 0;
        for (int i = 0; i < 32; i++) begin
          r <<= 1;
          q <<= 1;
          if (r >= den) begin
            r -= den;
            q |= 1;
          end
        end
      end
      q = (q + 1) >> 1;
      if (neg) begin
        if (q > 32768) q = 32768;
        w.cosine = 16'(17'h10000 - q);
      end else begin
        if (q > 32767) q = 32767;
        w.cosine = 16'(q);
      end
    end
    dot_acc = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    return 1'b1;
  endfunction

  // Short gap, mostly zero, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_word(logic signed [15:0] a, logic signed [15:0] b, bit last,
                           bit fixed, result_t fixed_word);
    result_t w;
    item_t it;
    it.elem_a = a;
    it.elem_b = b;
    it.last_element = last;
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    if (predict_cosine(a, b, last, w)) begin
      if (fixed && w != fixed_word)
        $display("%0t table row disagrees with predictor: %h vs %h", $time, fixed_word, w);
      expected_words.push_back(fixed ? fixed_word : w);
    end
    @(negedge clk);
    repeat (gap_len()) begin
      push <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Register write while the block is idle.
  task automatic write_floor(logic [FLOOR_W-1:0] v);
    push <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    floor_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_vector();
    int n, kind;
    logic signed [15:0] a, b;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
    kind = $urandom_range(0, 7);
    for (int i = 0; i < n; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (kind)
        0: b = a;
        1: b = -a;
        2: begin
          a = 16'($urandom_range(0, 3)) - 16'd2;
          b = 16'($urandom_range(0, 3)) - 16'd2;
        end
        3: a = 0;
        default: ;
      endcase
      send_word(a, b, i == n - 1, 1'b0, '0);
    end
  endtask

  // Result side: random pops and comparison with the oldest prediction.
  initial begin
    result_t w;
    @(negedge clk);
    forever begin
      pop <= pop_enable && ($urandom_range(0, 99) < 70 || $urandom_range(0, 1));
      if ($urandom_range(0, 39) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(5, 80)) @(negedge clk);
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t unexpected word: expected none actual %h", $time, result);
        end else begin
          w = expected_words.pop_front();
          if (result.cosine !== w.cosine) begin
            errors++;
            $display("%0t cosine mismatch: expected %0d actual %0d", $time, w.cosine,
                     result.cosine);
          end
          if (result.degenerate !== w.degenerate) begin
            errors++;
            $display("%0t degenerate mismatch: expected %b actual %b", $time,
                     w.degenerate, result.degenerate);
          end
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    result_t zero_deg, plus_one, minus_one;
    zero_deg = '{cosine: 16'sd0, degenerate: 1'b1};
    plus_one = '{cosine: 16'sd32767, degenerate: 1'b0};
    minus_one = '{cosine: -16'sd32768, degenerate: 1'b0};
    dot_acc = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    floor_reg = FLOOR_RESET;

    // Zero vectors, parallel and opposite extremes, small values near the floor.
    rows.push_back('{0, 0, 1, 1, zero_deg});
    rows.push_back('{16'sh7FFF, 16'sh7FFF, 1, 1, plus_one});
    rows.push_back('{-16'sh8000, -16'sh8000, 1, 1, plus_one});
    rows.push_back('{-16'sh8000, 16'sh7FFF, 1, 1, minus_one});
    rows.push_back('{16'sh7FFF, -16'sh8000, 1, 1, minus_one});
    rows.push_back('{1, 1, 1, 0, '0});
    rows.push_back('{1, -1, 1, 0, '0});
    rows.push_back('{5, 0, 1, 1, zero_deg});
    rows.push_back('{16'sh7FFF, 0, 0, 0, '0});
    rows.push_back('{0, 16'sh7FFF, 1, 0, '0});
    rows.push_back('{16'sh1234, -16'sh0567, 0, 0, '0});
    rows.push_back('{-16'sh5555, 16'sh2AAA, 0, 0, '0});
    rows.push_back('{16'sh0FFF, 16'sh7000, 1, 0, '0});
    rows.push_back('{3, 4, 0, 0, '0});
    rows.push_back('{4, 3, 1, 0, '0});

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_word(rows[i].a, rows[i].b, rows[i].last, rows[i].fixed,
                                rows[i].word);

    // Long vector of extremes builds large sums.
    for (int i = 0; i < 300; i++) send_word(-16'sh8000, -16'sh8000, i == 299, 1'b0, '0);

    write_floor('1);
    for (int i = 0; i < 15; i++) random_vector();
    write_floor('0);
    for (int i = 0; i < 15; i++) random_vector();

    // Hold the sender until every word has come.
    push <= 1'b0;
    wait (expected_words.size() == 0);
    @(negedge clk);

    write_floor(20'h00400);
    for (int i = 0; i < 20; i++) random_vector();
    write_floor(FLOOR_RESET);
    for (int i = 0; i < 40; i++) random_vector();

    push <= 1'b0;
    wait (expected_words.size() == 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
